>>> src/hcd_pkg.sv
package hcd_pkg;

   localparam int unsigned HASH_W = 64;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned DEBOUNCE_W = 16;
   localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
   localparam int unsigned HASH_SHIFT = 5;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd300;

   typedef enum logic [2:0] {
      CMD_BYTE  = 3'd0,
      CMD_EMPTY = 3'd1,
      CMD_RESET = 3'd2,
      CMD_FORCE = 3'd3,
      CMD_CHECK = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      VERDICT_NEW       = 2'd0,
      VERDICT_SAME      = 2'd1,
      VERDICT_DEBOUNCED = 2'd2,
      VERDICT_DUPLICATE = 2'd3
   } verdict_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_READ,
      ST_CMP,
      ST_NEW,
      ST_OUT
   } state_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] value);
      logic [COUNT_W-1:0] result;
      result = (value == {COUNT_W{1'b1}}) ? value : value + 1'b1;
      return result;
   endfunction

endpackage

>>> src/hashed_change_detector.sv
// A text byte without end mark is absorbed in its transfer cycle. A check (end of text,
// empty text, supplied hash) passes the evaluate state, then a window search and the
// new-entry state where needed, and then shows its result.
// The window memory is searched one entry at a time (read, then compare).
// Throughput: one item at a time; no new item is taken until the result is transferred.
// Reset is synchronous: debounce_ms returns to 300, counters and window fill clear.
module hashed_change_detector
   import hcd_pkg::*;
#(
   parameter int unsigned WINDOW_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [DEBOUNCE_W-1:0] csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_command,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,
   input  logic [TIME_W-1:0]     req_now_ms,
   input  logic [HASH_W-1:0]     req_given_hash,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_is_new,
   output logic [HASH_W-1:0]     rsp_text_hash,
   output logic [1:0]            rsp_verdict,
   output logic                  rsp_has_changed,
   output logic [COUNT_W-1:0]    rsp_total_changes,
   output logic [COUNT_W-1:0]    rsp_duplicates_skipped,
   output logic [COUNT_W-1:0]    rsp_hash_matches
);

   localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);
   localparam logic [FW-1:0] FULL_FILL = FW'(WINDOW_DEPTH);

   state_type          state_ff, state_in;
   logic [HASH_W-1:0]  running_hash_ff, running_hash_in;
   logic [HASH_W-1:0]  accepted_hash_ff, accepted_hash_in;
   logic [TIME_W-1:0]  change_time_ff, change_time_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [AW-1:0]      tail_ff, tail_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic [COUNT_W-1:0] change_total_ff, change_total_in;
   logic [COUNT_W-1:0] duplicate_total_ff, duplicate_total_in;
   logic [COUNT_W-1:0] match_total_ff, match_total_in;
   logic               changed_flag_ff, changed_flag_in;
   logic [DEBOUNCE_W-1:0] debounce_ff;
   logic [HASH_W-1:0]  chk_hash_ff, chk_hash_in;
   logic [TIME_W-1:0]  chk_now_ff, chk_now_in;
   verdict_type        verdict_ff, verdict_in;
   logic [AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]      cnt_ff, cnt_in;
   logic [HASH_W-1:0]  rd_data_ff;

   logic [HASH_W-1:0]  window_mem [WINDOW_DEPTH];
   logic               mem_we;

   logic               req_xfer;
   logic [HASH_W-1:0]  folded_hash;
   logic [TIME_W-1:0]  elapsed;

   function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] addr);
      logic [AW-1:0] result;
      result = (addr == LAST_ADDR) ? '0 : addr + 1'b1;
      return result;
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign folded_hash = (running_hash_ff << HASH_SHIFT) + running_hash_ff
                        + {{(HASH_W-8){1'b0}}, req_data_byte};
   assign elapsed = chk_now_ff - change_time_ff;

   assign rsp_valid              = (state_ff == ST_OUT);
   assign rsp_is_new             = (verdict_ff == VERDICT_NEW);
   assign rsp_text_hash          = chk_hash_ff;
   assign rsp_verdict            = verdict_ff;
   assign rsp_has_changed        = changed_flag_ff;
   assign rsp_total_changes      = change_total_ff;
   assign rsp_duplicates_skipped = duplicate_total_ff;
   assign rsp_hash_matches       = match_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         running_hash_ff    <= HASH_SEED;
         accepted_hash_ff   <= '0;
         change_time_ff     <= '0;
         head_ff            <= '0;
         tail_ff            <= '0;
         fill_ff            <= '0;
         change_total_ff    <= '0;
         duplicate_total_ff <= '0;
         match_total_ff     <= '0;
         changed_flag_ff    <= 1'b0;
         debounce_ff        <= DEBOUNCE_RESET;
      end else begin
         state_ff           <= state_in;
         running_hash_ff    <= running_hash_in;
         accepted_hash_ff   <= accepted_hash_in;
         change_time_ff     <= change_time_in;
         head_ff            <= head_in;
         tail_ff            <= tail_in;
         fill_ff            <= fill_in;
         change_total_ff    <= change_total_in;
         duplicate_total_ff <= duplicate_total_in;
         match_total_ff     <= match_total_in;
         changed_flag_ff    <= changed_flag_in;
         if (csr_wr_en) begin
            debounce_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      chk_hash_ff <= chk_hash_in;
      chk_now_ff  <= chk_now_in;
      verdict_ff  <= verdict_in;
      rd_ptr_ff   <= rd_ptr_in;
      cnt_ff      <= cnt_in;
   end

   // Window memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         window_mem[tail_ff] <= chk_hash_ff;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= window_mem[rd_ptr_ff];
      end
   end

   always_comb begin
      state_in           = state_ff;
      running_hash_in    = running_hash_ff;
      accepted_hash_in   = accepted_hash_ff;
      change_time_in     = change_time_ff;
      head_in            = head_ff;
      tail_in            = tail_ff;
      fill_in            = fill_ff;
      change_total_in    = change_total_ff;
      duplicate_total_in = duplicate_total_ff;
      match_total_in     = match_total_ff;
      changed_flag_in    = changed_flag_ff;
      chk_hash_in        = chk_hash_ff;
      chk_now_in         = chk_now_ff;
      verdict_in         = verdict_ff;
      rd_ptr_in          = rd_ptr_ff;
      cnt_in             = cnt_ff;
      mem_we             = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               chk_now_in = req_now_ms;
               case (command_type'(req_command))
                  CMD_BYTE: begin
                     if (req_last_byte) begin
                        chk_hash_in     = folded_hash;
                        running_hash_in = HASH_SEED;
                        state_in        = ST_EVAL;
                     end else begin
                        running_hash_in = folded_hash;
                     end
                  end
                  CMD_EMPTY: begin
                     running_hash_in = HASH_SEED;
                     chk_hash_in     = '0;
                     state_in        = ST_EVAL;
                  end
                  CMD_RESET: begin
                     accepted_hash_in = '0;
                     change_time_in   = req_now_ms;
                     changed_flag_in  = 1'b0;
                     fill_in          = '0;
                     head_in          = tail_ff;
                     running_hash_in  = HASH_SEED;
                  end
                  CMD_FORCE: begin
                     accepted_hash_in = '0;
                     change_time_in   = req_now_ms
                                        - ({{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ff} + 1'b1);
                     fill_in          = '0;
                     head_in          = tail_ff;
                  end
                  CMD_CHECK: begin
                     chk_hash_in = req_given_hash;
                     state_in    = ST_EVAL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EVAL: begin
            priority if (chk_hash_ff == accepted_hash_ff) begin
               match_total_in  = sat_inc(match_total_ff);
               changed_flag_in = 1'b0;
               verdict_in      = VERDICT_SAME;
               state_in        = ST_OUT;
            end else if ((accepted_hash_ff != '0)
                         && (elapsed < {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ff})) begin
               verdict_in = VERDICT_DEBOUNCED;
               state_in   = ST_OUT;
            end else if (fill_ff == '0) begin
               state_in = ST_NEW;
            end else begin
               rd_ptr_in = head_ff;
               cnt_in    = '0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            priority if (rd_data_ff == chk_hash_ff) begin
               duplicate_total_in = sat_inc(duplicate_total_ff);
               verdict_in         = VERDICT_DUPLICATE;
               state_in           = ST_OUT;
            end else if (FW'(cnt_ff + 1'b1) == fill_ff) begin
               state_in = ST_NEW;
            end else begin
               cnt_in    = FW'(cnt_ff + 1'b1);
               rd_ptr_in = next_addr(rd_ptr_ff);
               state_in  = ST_READ;
            end
         end
         ST_NEW: begin
            // When the window is full the oldest entry is overwritten in place.
            mem_we  = 1'b1;
            tail_in = next_addr(tail_ff);
            if (fill_ff == FULL_FILL) begin
               head_in = next_addr(head_ff);
            end else begin
               fill_in = FW'(fill_ff + 1'b1);
            end
            accepted_hash_in = chk_hash_ff;
            change_time_in   = chk_now_ff;
            change_total_in  = sat_inc(change_total_ff);
            changed_flag_in  = 1'b1;
            verdict_in       = VERDICT_NEW;
            state_in         = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_FILL)
      else $error("window fill exceeds depth");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");

   a_search_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (cnt_ff < fill_ff))
      else $error("window search ran past the fill count");

   a_new_pushes_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEW) |=> (accepted_hash_ff == $past(chk_hash_ff)) && changed_flag_ff)
      else $error("accepted change did not update the last hash");

   a_result_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("result shown twice");

endmodule
